// File: hw/rtl/hkrt_pkg.sv
// Shared types and constants for the HID key report tracker.
// No dependencies; imported by hkrt_key_table and hid_key_report_tracker.
package hkrt_pkg;

    localparam int unsigned KEY_SLOTS_DEF = 6;
    localparam int unsigned REPORT_SLOTS  = 6;

    localparam logic [7:0] PAGE_KEYBOARD = 8'h07;
    localparam logic [7:0] PAGE_CONSUMER = 8'h0C;

    localparam logic [15:0] MOD_FIRST = 16'd224;
    localparam logic [15:0] MOD_LAST  = 16'd231;

    localparam logic REPORT_KIND_KEYBOARD = 1'b0;
    localparam logic REPORT_KIND_CONSUMER = 1'b1;

    typedef struct packed {
        logic        apply;
        logic [15:0] usage;
        logic        pressed;
    } hkrt_key_evt_t;

    typedef logic [REPORT_SLOTS-1:0][7:0] hkrt_slots_t;

endpackage

// File: hw/rtl/hkrt_key_table.sv
// Keyboard state of the tracker: modifier mask, key slots and fill count.
// Depends on hkrt_pkg for the event struct and the report slot type.
module hkrt_key_table #(
    parameter int unsigned KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hkrt_pkg::hkrt_key_evt_t evt,
    output logic [7:0]            mod_next,
    output hkrt_pkg::hkrt_slots_t slots_next
);
    import hkrt_pkg::*;

    localparam int unsigned CNT_W = $clog2(KEY_SLOTS + 1);
    localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [7:0]       mod_reg;
    logic [7:0]       keys_reg  [KEY_SLOTS];
    logic [7:0]       keys_next [KEY_SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] hit_idx;
    logic             hit;
    logic             is_mod;
    logic [7:0]       code;
    logic [7:0]       last_key;

    assign code      = evt.usage[7:0];
    assign is_mod    = (evt.usage >= MOD_FIRST) && (evt.usage <= MOD_LAST);
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign last_key  = keys_reg[last_idx];

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
            if ((CNT_W'(k) < count_reg) && (keys_reg[k] == code)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        mod_next   = mod_reg;
        count_next = count_reg;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            keys_next[k] = keys_reg[k];
        end
        if (evt.apply) begin
            if (is_mod) begin
                if (evt.pressed) begin
                    mod_next = mod_reg | (8'd1 << evt.usage[2:0]);
                end else begin
                    mod_next = mod_reg & ~(8'd1 << evt.usage[2:0]);
                end
            end else if (evt.pressed) begin
                if (count_reg < CNT_W'(KEY_SLOTS)) begin
                    for (int k = 0; k < KEY_SLOTS; k++) begin
                        if (CNT_W'(k) == count_reg) begin
                            keys_next[k] = code;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (hit) begin
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    if (IDX_W'(k) == last_idx) begin
                        keys_next[k] = 8'd0;
                    end else if (IDX_W'(k) == hit_idx) begin
                        keys_next[k] = last_key;
                    end
                end
                count_next = count_dec;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            slots_next[j] = 8'd0;
        end
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (j < KEY_SLOTS) begin
                slots_next[j] = keys_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg   <= 8'd0;
            count_reg <= '0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                keys_reg[k] <= 8'd0;
            end
        end else begin
            mod_reg   <= mod_next;
            count_reg <= count_next;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                keys_reg[k] <= keys_next[k];
            end
        end
    end

endmodule

// File: hw/rtl/hid_key_report_tracker.sv
// Top level of the HID key report tracker: input register, event decode,
// report register. Depends on hkrt_pkg and hkrt_key_table.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   usage_page, usage_code, pressed, link_mounted
//  m_       out        m_valid / m_ready   report_kind, modifier_mask, key_slot0..5,
//                                          consumer_code
//
// A request is registered in the input register on acceptance and its report is then written
// to the report register, which drives m_valid; one request enters per cycle unless the report stalls.
// Requests on other pages or with the link down leave no report and no state change.
// Synchronous active-low reset clears all key state and empties both registers.
// A stalled report holds the pipe; the input register still takes one request.
module hid_key_report_tracker #(
    parameter int unsigned KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_usage_page,
    input  logic [15:0] s_usage_code,
    input  logic        s_pressed,
    input  logic        s_link_mounted,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_report_kind,
    output logic [7:0]  m_modifier_mask,
    output logic [7:0]  m_key_slot0,
    output logic [7:0]  m_key_slot1,
    output logic [7:0]  m_key_slot2,
    output logic [7:0]  m_key_slot3,
    output logic [7:0]  m_key_slot4,
    output logic [7:0]  m_key_slot5,
    output logic [15:0] m_consumer_code
);
    import hkrt_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_page_reg;
    logic [15:0] in_code_reg;
    logic        in_pressed_reg;
    logic        in_mounted_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_kind_reg;
    logic [7:0]  out_mask_reg;
    hkrt_slots_t out_slots_reg;
    logic [15:0] out_cons_reg;

    logic          advance;
    logic          is_kbd;
    logic          is_cons;
    logic          emit;
    hkrt_key_evt_t key_evt;
    logic [7:0]    mod_next;
    hkrt_slots_t   slots_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign is_kbd  = in_mounted_reg && (in_page_reg == PAGE_KEYBOARD);
    assign is_cons = in_mounted_reg && (in_page_reg == PAGE_CONSUMER);
    assign emit    = advance && (is_kbd || is_cons);
    assign s_ready = !in_valid_reg || advance;

    assign key_evt.apply   = advance && is_kbd;
    assign key_evt.usage   = in_code_reg;
    assign key_evt.pressed = in_pressed_reg;

    hkrt_key_table #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_key_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (key_evt),
        .mod_next  (mod_next),
        .slots_next(slots_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_page_reg    <= s_usage_page;
            in_code_reg    <= s_usage_code;
            in_pressed_reg <= s_pressed;
            in_mounted_reg <= s_link_mounted;
        end
        if (emit) begin
            if (is_kbd) begin
                out_kind_reg  <= REPORT_KIND_KEYBOARD;
                out_mask_reg  <= mod_next;
                out_slots_reg <= slots_next;
                out_cons_reg  <= 16'd0;
            end else begin
                out_kind_reg  <= REPORT_KIND_CONSUMER;
                out_mask_reg  <= 8'd0;
                out_slots_reg <= '0;
                out_cons_reg  <= in_pressed_reg ? in_code_reg : 16'd0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_report_kind   = out_kind_reg;
    assign m_modifier_mask = out_mask_reg;
    assign m_key_slot0     = out_slots_reg[0];
    assign m_key_slot1     = out_slots_reg[1];
    assign m_key_slot2     = out_slots_reg[2];
    assign m_key_slot3     = out_slots_reg[3];
    assign m_key_slot4     = out_slots_reg[4];
    assign m_key_slot5     = out_slots_reg[5];
    assign m_consumer_code = out_cons_reg;

endmodule
